@@ hw/rtl/rpe_pkg.sv @@
// Shared types and constants for the run-length packet encoder.
// No dependencies; compile this file first.
`timescale 1ns / 1ps

package rpe_pkg;

    localparam int MAX_PACKET = 60;
    localparam int CNT_W      = 7;
    localparam int ADDR_W     = $clog2(MAX_PACKET);
    localparam int BYTE_W     = 8;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [CNT_W-1:0]  count_t;
    typedef logic [ADDR_W-1:0] addr_t;

    // Literal packet header base; a literal header is LIT_BASE plus the count.
    localparam byte_t LIT_BASE = 8'd128;

    typedef struct packed {
        logic  en;
        addr_t addr;
        byte_t data;
    } rpe_wr_t;

endpackage

@@ hw/rtl/rpe_if.sv @@
// Channel interfaces of the run-length packet encoder: raw bytes in, encoded bytes out.
// Depends on rpe_pkg.
`timescale 1ns / 1ps

interface rpe_in_if import rpe_pkg::*; ();
    logic  valid;
    logic  ready;
    byte_t data_byte;
    logic  end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface rpe_out_if import rpe_pkg::*; ();
    logic  valid;
    logic  ready;
    byte_t out_byte;
    logic  last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

@@ hw/rtl/rpe_buffer.sv @@
// Packet buffer: one write port, one read port with registered read data.
// Depends on rpe_pkg.
`timescale 1ns / 1ps

module rpe_buffer import rpe_pkg::*;
(
    input  logic    clk,
    input  rpe_wr_t wr,
    input  addr_t   rd_addr,
    output byte_t   rd_data
);

    byte_t mem [MAX_PACKET];
    byte_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/rle_packet_encoder_core.sv @@
// Run-length packet encoder top level: sequencer, output register and buffer instance.
// Depends on rpe_pkg, rpe_in_if / rpe_out_if and rpe_buffer.
//
// Usage: raw bytes enter on the raw channel (data_byte, end_of_stream), one per
// transaction. Encoded bytes leave on the enc channel; last marks the final byte
// caused by one raw transaction. A run leaves as header = count, then the byte;
// a literal leaves as header = 128 + count, then its bytes.
// Timing: a raw byte that only joins the pending packet leaves the block ready
// for the next raw byte. A flush loads the header, then replays each byte as a
// buffer read (S_RD) followed by an output load (S_LIT); a run replays one byte
// and an n-byte literal n bytes. An extra lone byte after a flush adds its own
// header (S_THDR) and byte (S_TB). The replay rate is set by the single
// registered read port of the buffer. Raw ready is low while a flush is in progress.
// Reset clears the pending packet and the output register; the buffer is not
// cleared, since only entries written for the current packet are replayed.
// When the receiver stalls, the output register holds its byte and the sequencer
// waits; no encoded byte is dropped.
`timescale 1ns / 1ps

module rle_packet_encoder_core import rpe_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    rpe_in_if.sink    raw,
    rpe_out_if.source enc
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_HDR  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_LIT  = 3'd3;
    localparam logic [2:0] S_THDR = 3'd4;
    localparam logic [2:0] S_TB   = 3'd5;

    logic [2:0] state_reg, state_next;
    count_t     count_reg, count_next;
    logic       run_reg, run_next;
    byte_t      newest_reg, newest_next;
    byte_t      pend_reg, pend_next;
    logic       tail_reg, tail_next;
    logic       wr0_reg, wr0_next;
    byte_t      hdr_reg, hdr_next;
    count_t     lim_reg, lim_next;
    count_t     idx_reg, idx_next;

    logic       out_valid_reg;
    byte_t      out_byte_reg;
    logic       out_last_reg;

    rpe_wr_t    wr;
    byte_t      rd_data;
    logic       slot_free;
    logic       load;
    byte_t      load_byte;
    logic       load_last;
    logic       fl_go;
    count_t     fl_cnt;
    logic       fl_run;
    logic       eq;
    logic       brk;
    logic       idx_end;

    rpe_buffer u_buffer
    (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (idx_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    assign slot_free = !out_valid_reg || enc.ready;
    assign raw.ready = (state_reg == S_IDLE);
    assign eq        = (raw.data_byte == newest_reg);
    assign brk       = (eq != run_reg) || (count_reg >= CNT_W'(MAX_PACKET));
    assign idx_end   = ((idx_reg + CNT_W'(1)) == lim_reg);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        run_next    = run_reg;
        newest_next = newest_reg;
        pend_next   = pend_reg;
        tail_next   = tail_reg;
        wr0_next    = wr0_reg;
        hdr_next    = hdr_reg;
        lim_next    = lim_reg;
        idx_next    = idx_reg;
        wr          = '0;
        load        = 1'b0;
        load_byte   = '0;
        load_last   = 1'b0;
        fl_go       = 1'b0;
        fl_cnt      = count_reg;
        fl_run      = run_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (raw.valid)
                begin
                    newest_next = raw.data_byte;
                    tail_next   = 1'b0;
                    wr0_next    = 1'b0;
                    if (count_reg == '0)
                    begin
                        wr         = '{en: 1'b1, addr: '0, data: raw.data_byte};
                        count_next = CNT_W'(1);
                        run_next   = 1'b0;
                        fl_go      = raw.end_of_stream;
                        fl_cnt     = CNT_W'(1);
                        fl_run     = 1'b0;
                    end
                    else if (count_reg == CNT_W'(1))
                    begin
                        wr         = '{en: 1'b1, addr: ADDR_W'(1), data: raw.data_byte};
                        count_next = CNT_W'(2);
                        run_next   = eq;
                        fl_go      = raw.end_of_stream;
                        fl_cnt     = CNT_W'(2);
                        fl_run     = eq;
                    end
                    else if (brk)
                    begin
                        // Flush the old packet first; the new byte waits in pend.
                        fl_go      = 1'b1;
                        pend_next  = raw.data_byte;
                        tail_next  = raw.end_of_stream;
                        wr0_next   = !raw.end_of_stream;
                        count_next = raw.end_of_stream ? '0 : CNT_W'(1);
                        run_next   = 1'b0;
                    end
                    else
                    begin
                        wr = '{en: 1'b1, addr: count_reg[ADDR_W-1:0],
                               data: raw.data_byte};
                        count_next = count_reg + CNT_W'(1);
                        fl_go      = raw.end_of_stream;
                        fl_cnt     = count_reg + CNT_W'(1);
                    end

                    if (fl_go)
                    begin
                        if (fl_run && (fl_cnt >= CNT_W'(2)))
                        begin
                            hdr_next = BYTE_W'(fl_cnt);
                            lim_next = CNT_W'(1);
                        end
                        else
                        begin
                            hdr_next = LIT_BASE | BYTE_W'(fl_cnt);
                            lim_next = fl_cnt;
                        end
                        idx_next   = '0;
                        state_next = S_HDR;
                        if (raw.end_of_stream && !brk)
                        begin
                            count_next = '0;
                            run_next   = 1'b0;
                        end
                        if (raw.end_of_stream && (count_reg < CNT_W'(2)))
                        begin
                            count_next = '0;
                            run_next   = 1'b0;
                        end
                    end
                end
            end

            S_HDR:
            begin
                if (slot_free)
                begin
                    load       = 1'b1;
                    load_byte  = hdr_reg;
                    state_next = S_RD;
                end
            end

            S_RD:
            begin
                // Wait for the registered buffer read at idx.
                state_next = S_LIT;
            end

            S_LIT:
            begin
                if (slot_free)
                begin
                    load      = 1'b1;
                    load_byte = rd_data;
                    load_last = idx_end && !tail_reg;
                    idx_next  = idx_reg + CNT_W'(1);
                    if (!idx_end)
                    begin
                        state_next = S_RD;
                    end
                    else if (tail_reg)
                    begin
                        state_next = S_THDR;
                    end
                    else
                    begin
                        // Old packet replayed; now start the new one with pend.
                        wr.en      = wr0_reg;
                        wr.addr    = '0;
                        wr.data    = pend_reg;
                        state_next = S_IDLE;
                    end
                end
            end

            S_THDR:
            begin
                if (slot_free)
                begin
                    load       = 1'b1;
                    load_byte  = LIT_BASE + BYTE_W'(1);
                    state_next = S_TB;
                end
            end

            S_TB:
            begin
                if (slot_free)
                begin
                    load       = 1'b1;
                    load_byte  = pend_reg;
                    load_last  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            run_reg       <= 1'b0;
            tail_reg      <= 1'b0;
            wr0_reg       <= 1'b0;
            idx_reg       <= '0;
            lim_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            run_reg   <= run_next;
            tail_reg  <= tail_next;
            wr0_reg   <= wr0_next;
            idx_reg   <= idx_next;
            lim_reg   <= lim_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (enc.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        newest_reg <= newest_next;
        pend_reg   <= pend_next;
        hdr_reg    <= hdr_next;
        if (load)
        begin
            out_byte_reg <= load_byte;
            out_last_reg <= load_last;
        end
    end

    assign enc.valid    = out_valid_reg;
    assign enc.out_byte = out_byte_reg;
    assign enc.last     = out_last_reg;

    // The pending packet never grows past the cap.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_PACKET))
        else $error("pending packet count exceeds cap");

    // End of stream always leaves an empty pending packet.
    assert property (@(posedge clk) disable iff (!rst_n)
        raw.valid && raw.ready && raw.end_of_stream |=> count_reg == '0)
        else $error("pending packet not cleared at end of stream");

    // Replay index stays inside the packet being flushed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LIT) |-> (idx_reg < lim_reg))
        else $error("replay index beyond packet length");

    // A deferred restart write and a lone-byte tail never coexist.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !(tail_reg && wr0_reg))
        else $error("tail and restart write both pending");

    // An output byte is loaded only into a free slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        load |-> slot_free)
        else $error("output register overwritten while stalled");

endmodule

@@ tb/rle_packet_encoder_core_tb.sv @@
// Self-checking testbench for rle_packet_encoder_core: raw bytes in, encoded packets out.
// Depends on rpe_pkg, rpe_in_if / rpe_out_if and the rle_packet_encoder_core RTL.
// An in-bench packet model predicts every encoded byte; a monitor checks them in order.
`timescale 1ns / 1ps

module rle_packet_encoder_core_tb;
    import rpe_pkg::*;

    localparam int  MAX_REPORTS = 30;
    localparam int  DRAIN_LIMIT = 20000;
    localparam int  TAIL_CYCLES = 200;

    typedef struct {
        byte_t out_byte;
        logic  last;
    } enc_byte_t;

    logic clk;
    logic rst_n;

    rpe_in_if  raw_if ();
    rpe_out_if enc_if ();

    rle_packet_encoder_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .raw   (raw_if),
        .enc   (enc_if)
    );

    // Packet model state
    byte_t       pkt_bytes [MAX_PACKET];
    int unsigned pkt_len    = 0;
    bit          pkt_is_run = 1'b0;
    enc_byte_t   enc_expected [$];

    int unsigned err_count    = 0;
    int unsigned enc_seen     = 0;
    int unsigned src_idle_pct = 0;
    int unsigned snk_idle_pct = 0;
    logic        sink_hold    = 1'b0;
    byte_t       last_byte    = '0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10ms;
        $display("TEST FAILED");
        $finish;
    end

    task automatic report_mismatch(string what, int expv, int gotv);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s at encoded byte %0d: expected 0x%0h, got 0x%0h",
                     $realtime, what, enc_seen, expv, gotv);
    endtask

    // Append one byte at the tail of a byte queue.
    function automatic void append_byte(ref byte_t q [$], input byte_t v);
        q.insert(q.size(), v);
    endfunction

    function automatic void emit_packet(ref byte_t step_out [$]);
        if (pkt_len == 0)
            return;
        if (pkt_len >= 2 && pkt_is_run)
        begin
            append_byte(step_out, byte_t'(pkt_len));
            append_byte(step_out, pkt_bytes[0]);
        end
        else
        begin
            append_byte(step_out, byte_t'(LIT_BASE + pkt_len));
            for (int i = 0; i < pkt_len; i++)
                append_byte(step_out, pkt_bytes[i]);
        end
        pkt_len    = 0;
        pkt_is_run = 1'b0;
    endfunction

    function automatic void predict_encoding(byte_t b, logic eos);
        byte_t     step_out [$];
        bit        match;
        enc_byte_t eb;
        if (pkt_len == 0)
        begin
            pkt_bytes[0] = b;
            pkt_len      = 1;
            pkt_is_run   = 1'b0;
        end
        else if (pkt_len == 1)
        begin
            pkt_is_run   = (b == pkt_bytes[0]);
            pkt_bytes[1] = b;
            pkt_len      = 2;
        end
        else
        begin
            match = (b == pkt_bytes[pkt_len-1]);
            // kind break or full packet: flush, then start over with this byte
            if (match != pkt_is_run || pkt_len >= MAX_PACKET)
            begin
                emit_packet(step_out);
                pkt_bytes[0] = b;
                pkt_len      = 1;
                pkt_is_run   = 1'b0;
            end
            else
            begin
                pkt_bytes[pkt_len] = b;
                pkt_len++;
            end
        end
        if (eos)
            emit_packet(step_out);
        foreach (step_out[i])
        begin
            eb.out_byte = step_out[i];
            eb.last     = (i == step_out.size() - 1);
            enc_expected.insert(enc_expected.size(), eb);
        end
    endfunction

    // Offer one raw transaction; valid stays high so back-to-back items need no toggle.
    task automatic send_byte(byte_t b, logic eos);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            raw_if.valid <= 1'b0;
            @(posedge clk);
        end
        raw_if.valid         <= 1'b1;
        raw_if.data_byte     <= b;
        raw_if.end_of_stream <= eos;
        @(posedge clk);
        while (!raw_if.ready)
            @(posedge clk);
        predict_encoding(b, eos);
        last_byte = b;
    endtask

    task automatic send_run(byte_t b, int unsigned len, logic eos);
        for (int i = 1; i < len; i++)
            send_byte(b, 1'b0);
        send_byte(b, eos);
    endtask

    task automatic send_literal(int unsigned len, logic eos);
        byte_t b;
        for (int i = 0; i < len; i++)
        begin
            b = byte_t'($urandom);
            if (b == last_byte)
                b = ~b;
            send_byte(b, eos && (i == len - 1));
        end
    endtask

    // Monitor and receiver: check each accepted encoded byte, then pick next ready.
    always @(posedge clk)
    begin
        enc_byte_t exp_b;
        if (rst_n && enc_if.valid && enc_if.ready)
        begin
            if (enc_expected.size() == 0)
                report_mismatch("unexpected encoded byte", 0, enc_if.out_byte);
            else
            begin
                exp_b = enc_expected.pop_front();
                if (enc_if.out_byte !== exp_b.out_byte)
                    report_mismatch("out_byte", exp_b.out_byte, enc_if.out_byte);
                if (enc_if.last !== exp_b.last)
                    report_mismatch("last", exp_b.last, enc_if.last);
            end
            enc_seen++;
        end
        enc_if.ready <= rst_n && !sink_hold && ($urandom_range(0, 99) >= snk_idle_pct);
    end

    task automatic hold_receiver(int unsigned cycles);
        sink_hold <= 1'b1;
        repeat (cycles) @(posedge clk);
        sink_hold <= 1'b0;
    endtask

    task automatic test_directed();
        send_byte(8'h00, 1'b1);             // lone byte, low extreme
        send_byte(8'hFF, 1'b1);             // lone byte, high extreme
        send_run(8'hAA, 3, 1'b1);           // plain run
        send_run(8'h7F, 2, 1'b1);           // shortest run
        send_byte(8'h01, 1'b0);             // plain literal
        send_byte(8'h02, 1'b0);
        send_byte(8'h03, 1'b1);
        send_byte(8'h80, 1'b0);             // shortest literal
        send_byte(8'h81, 1'b1);
        send_run(8'h55, 3, 1'b0);           // run broken by a new byte on the last item
        send_byte(8'h12, 1'b1);
        send_byte(8'h10, 1'b0);             // literal broken by a repeat
        send_byte(8'h20, 1'b0);
        send_byte(8'h30, 1'b0);
        send_byte(8'h30, 1'b1);
        send_run(8'h3C, 2, 1'b0);           // run, then a two-byte literal started by the byte that breaks it
        send_byte(8'hC3, 1'b0);
        send_byte(8'h5A, 1'b1);
    endtask

    task automatic test_full_packet();
        send_run(8'hE7, MAX_PACKET + 1, 1'b1);
        // full literal plus a lone byte on one item: the most bytes one item can cause
        for (int i = 0; i < MAX_PACKET; i++)
            send_byte(byte_t'(i), 1'b0);
        send_byte(byte_t'(MAX_PACKET), 1'b1);
    endtask

    task automatic test_random_streams(int unsigned n_items);
        int unsigned sent;
        int unsigned len;
        logic        eos;
        sent = 0;
        while (sent < n_items)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, MAX_PACKET + 5)
                                               : $urandom_range(1, 6);
            eos = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    for (int i = 0; i < len; i++)
                        send_byte(byte_t'($urandom), ($urandom_range(0, 7) == 0));
                end
                2, 3, 4, 5:
                    send_run(byte_t'($urandom), len, eos);
                default:
                    send_literal(len, eos);
            endcase
            sent += len;
        end
        // close the stream so no packet stays pending
        send_byte(byte_t'($urandom), 1'b1);
    endtask

    task automatic test_backpressure();
        fork
            hold_receiver(400);
        join_none
        send_literal(8, 1'b0);
        send_run(8'h99, 5, 1'b0);
        send_literal(5, 1'b1);
    endtask

    initial
    begin
        rst_n                <= 1'b0;
        raw_if.valid         <= 1'b0;
        raw_if.data_byte     <= '0;
        raw_if.end_of_stream <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct = 18;
        snk_idle_pct = 46;
        test_directed();
        test_full_packet();
        test_random_streams(5);

        src_idle_pct = 46;
        snk_idle_pct = 18;
        test_random_streams(5);
        test_backpressure();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random_streams(5);

        raw_if.valid <= 1'b0;
        fork
            wait (enc_expected.size() == 0);
            repeat (DRAIN_LIMIT) @(posedge clk);
        join_any
        disable fork;
        repeat (TAIL_CYCLES) @(posedge clk);
        if (enc_expected.size() != 0)
            report_mismatch("encoded bytes never arrived", enc_expected.size(), 0);

        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/rpe_pkg.sv
hw/rtl/rpe_if.sv
hw/rtl/rpe_buffer.sv
hw/rtl/rle_packet_encoder_core.sv
tb/rle_packet_encoder_core_tb.sv
